[rtl/char_lcd_refresh_scanner_core_assert.svh]
// Assertion macros shared by the scanner modules.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef CHAR_LCD_REFRESH_SCANNER_CORE_ASSERT_SVH
`define CHAR_LCD_REFRESH_SCANNER_CORE_ASSERT_SVH

// Same-cycle implication.
`define CLRS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CLRS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/clrs_pkg.sv]
package clrs_pkg;

  localparam int ROWS       = 4;
  localparam int COLS       = 17;
  localparam int INIT_STEPS = 10;

  localparam int TEXT_COLS = COLS - 1;
  localparam int CELLS     = ROWS * TEXT_COLS;
  localparam int ADDR_W    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int COL_W     = $clog2(COLS);
  localparam int CMP_W     = 7;

  localparam logic [7:0] SPACE_CHAR = 8'h20;
  localparam logic [7:0] DIGIT_BASE = 8'd48;

  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_LOAD = 1'b1;
  localparam logic RS_CMD    = 1'b0;
  localparam logic RS_DATA   = 1'b1;

  localparam int INIT_TABLE_LEN = 10;
  localparam logic [7:0] INIT_TABLE [INIT_TABLE_LEN] = '{
    8'h30, 8'h30, 8'h30, 8'h38, 8'h10, 8'hC0, 8'h06, 8'h01, 8'h0F, 8'h0D
  };

  localparam int NUM_LINES = 4;
  localparam logic [7:0] LINE_RESET [NUM_LINES] = '{8'h80, 8'hC0, 8'h90, 8'hD0};

  typedef struct packed {
    logic       mode;
    logic [1:0] row_sel;
    logic [3:0] col_sel;
    logic [7:0] char_in;
  } in_item_t;

  typedef struct packed {
    logic       reg_select;
    logic [7:0] lcd_byte;
  } out_item_t;

  typedef struct packed {
    logic tick_go;
    logic load_go;
    logic out_load;
  } ctl_cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_FETCH
  } ctl_state_t;

endpackage

[rtl/char_lcd_refresh_scanner_core.sv]
// Character LCD refresh scanner: init command sequence, then an endless text scan.
// A tick's result passes the pending registers, beside the registered read of the text
// store RAM, then the output register; a character load gives no result. Sustained
// rate: one load per cycle while idle; a tick blocks input until its result is loaded.
// Synchronous active-low reset restores the line addresses, clears the cursors and
// marks every text cell as a space through per-cell valid bits, with no clearing pass.
module char_lcd_refresh_scanner_core
  import clrs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_item,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_item,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata
);

  ctl_cmd_t cmd;

  clrs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_item.mode),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cmd      (cmd)
  );

  clrs_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_item  (in_item),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .out_item (out_item)
  );

endmodule

[rtl/clrs_ram.sv]
module clrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/clrs_ctrl.sv]
`include "char_lcd_refresh_scanner_core_assert.svh"

module clrs_ctrl
  import clrs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_mode,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output ctl_cmd_t cmd
);

  ctl_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && (in_mode == MODE_TICK)) begin
          state_nxt = ST_FETCH;
        end
      end
      ST_FETCH: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    cmd          = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.tick_go = in_valid && (in_mode == MODE_TICK);
        cmd.load_go = in_valid && (in_mode == MODE_LOAD);
      end
      ST_FETCH: begin
        cmd.out_load = !out_valid_r || out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `CLRS_ASSERT_NEXT(a_tick_enters_fetch, cmd.tick_go, state_r == ST_FETCH, "tick did not enter fetch")
  `CLRS_ASSERT_NEXT(a_load_shows_result, cmd.out_load, out_valid_r, "loaded result not presented")
  `CLRS_ASSERT_NEXT(a_load_stays_idle, cmd.load_go, state_r == ST_IDLE && !cmd.out_load, "character load started a fetch")

endmodule

[rtl/clrs_dp.sv]
`include "char_lcd_refresh_scanner_core_assert.svh"

module clrs_dp
  import clrs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  ctl_cmd_t   cmd,
  input  in_item_t   in_item,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata,
  output out_item_t  out_item
);

  logic [7:0]       line_r [NUM_LINES];
  logic [3:0]       init_step_r, init_step_nxt;
  logic [1:0]       scan_row_r, scan_row_nxt;
  logic [COL_W-1:0] scan_col_r, scan_col_nxt;
  logic             pad_r, pad_nxt;
  logic [CELLS-1:0] vld_r;

  // Result pending while the store read completes.
  logic       pend_rs_r, pend_rs_nxt;
  logic [7:0] pend_byte_r, pend_byte_nxt;
  logic       pend_ram_r, pend_ram_nxt;
  logic       pend_vld_r, pend_vld_nxt;
  out_item_t  out_item_r;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        rd_data;
  logic [3:0]        init_sel;
  logic [1:0]        next_line;
  logic              pad_tmp;

  // Load path: values 1 to 9 become ASCII digits, and a zero pads the rest of the row load.
  always_comb begin
    pad_tmp = (in_item.col_sel == 4'd0) ? 1'b0 : pad_r;
    if (in_item.char_in == 8'd0) begin
      pad_tmp = 1'b1;
    end
    wr_en = cmd.load_go && (CMP_W'(in_item.row_sel) < CMP_W'(ROWS))
            && (CMP_W'(in_item.col_sel) < CMP_W'(TEXT_COLS));
    pad_nxt = wr_en ? pad_tmp : pad_r;
    if (pad_tmp) begin
      wr_data = SPACE_CHAR;
    end else if (in_item.char_in > 8'd9) begin
      wr_data = in_item.char_in;
    end else begin
      wr_data = in_item.char_in + DIGIT_BASE;
    end
    wr_addr = ADDR_W'(ADDR_W'(in_item.row_sel) * ADDR_W'(TEXT_COLS)
              + ADDR_W'(in_item.col_sel));
  end

  // Tick path: init commands first, then the scan of the store.
  always_comb begin
    init_step_nxt = init_step_r;
    scan_row_nxt  = scan_row_r;
    scan_col_nxt  = scan_col_r;
    pend_rs_nxt   = pend_rs_r;
    pend_byte_nxt = pend_byte_r;
    pend_ram_nxt  = pend_ram_r;
    pend_vld_nxt  = pend_vld_r;
    init_sel  = (init_step_r > 4'(INIT_TABLE_LEN - 1)) ? 4'(INIT_TABLE_LEN - 1)
                                                        : init_step_r;
    next_line = (scan_row_r == 2'(ROWS - 1)) ? 2'd0 : scan_row_r + 2'd1;
    rd_addr   = ADDR_W'(ADDR_W'(scan_row_r) * ADDR_W'(TEXT_COLS)
                + ADDR_W'(scan_col_r));
    if (cmd.tick_go) begin
      if (init_step_r < 4'(INIT_STEPS)) begin
        pend_rs_nxt   = RS_CMD;
        pend_byte_nxt = INIT_TABLE[init_sel];
        pend_ram_nxt  = 1'b0;
        init_step_nxt = init_step_r + 4'd1;
      end else if (scan_col_r == COL_W'(COLS - 1)) begin
        // The last cell of a row is the set-address command of the next line.
        pend_rs_nxt   = RS_CMD;
        pend_byte_nxt = line_r[next_line];
        pend_ram_nxt  = 1'b0;
        scan_row_nxt  = next_line;
        scan_col_nxt  = '0;
      end else begin
        pend_rs_nxt  = RS_DATA;
        pend_ram_nxt = 1'b1;
        pend_vld_nxt = vld_r[rd_addr];
        scan_col_nxt = scan_col_r + COL_W'(1);
      end
    end
  end

  clrs_ram #(
    .WIDTH(8),
    .DEPTH(CELLS)
  ) u_text_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(wr_data),
    .re   (cmd.tick_go),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_LINES; i++) begin
        line_r[i] <= LINE_RESET[i];
      end
      init_step_r <= '0;
      scan_row_r  <= '0;
      scan_col_r  <= '0;
      pad_r       <= 1'b0;
      vld_r       <= '0;
    end else begin
      if (cfg_we) begin
        line_r[cfg_index] <= cfg_wdata;
      end
      init_step_r <= init_step_nxt;
      scan_row_r  <= scan_row_nxt;
      scan_col_r  <= scan_col_nxt;
      pad_r       <= pad_nxt;
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_rs_r   <= pend_rs_nxt;
    pend_byte_r <= pend_byte_nxt;
    pend_ram_r  <= pend_ram_nxt;
    pend_vld_r  <= pend_vld_nxt;
    if (cmd.out_load) begin
      out_item_r.reg_select <= pend_rs_r;
      if (pend_ram_r) begin
        out_item_r.lcd_byte <= pend_vld_r ? rd_data : SPACE_CHAR;
      end else begin
        out_item_r.lcd_byte <= pend_byte_r;
      end
    end
  end

  assign out_item = out_item_r;

  `CLRS_ASSERT_NOW(a_col_in_range, 1'b1, scan_col_r <= COL_W'(COLS - 1), "scan column out of range")
  `CLRS_ASSERT_NEXT(a_row_wrap, cmd.tick_go && init_step_r >= 4'(INIT_STEPS) && scan_col_r == COL_W'(COLS - 1), scan_col_r == '0 && !pend_ram_r, "row end did not wrap the scan")
  `CLRS_ASSERT_NEXT(a_init_count, cmd.tick_go && init_step_r < 4'(INIT_STEPS), init_step_r == $past(init_step_r) + 4'd1 && pend_rs_r == RS_CMD, "init step did not advance")

endmodule
